/* hw/rtl/plil_pkg.sv */
// shared types and constants for the positional list
package plil_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ACT_W    = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 7;
    localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int IN_W     = ((ACT_W + VAL_W + POS_W + 7) / 8) * 8;
    localparam int OUT_W    = ((STAT_W + LEN_W + VAL_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4,
        ACT_DEL_AT    = 3'd5,
        ACT_READ_AT   = 3'd6
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             rd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
    } t_cell_ctl;

endpackage

/* hw/rtl/plil_cell.sv */
// one storage cell of the list row, shifting to or from its neighbors
module plil_cell
    import plil_pkg::*;
(
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctl        i_ctl,
    input  logic [VAL_W-1:0] i_left,
    input  logic [VAL_W-1:0] i_right,
    output logic [VAL_W-1:0] o_data,
    output logic [VAL_W-1:0] o_tap
);

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (i_index == i_ctl.idx) begin
                n_data = i_ctl.val;
            end else if (i_index > i_ctl.idx) begin
                n_data = i_left;
            end
        end else if (i_ctl.del) begin
            if (i_index >= i_ctl.idx) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // gated read tap, or-combined across the row
    assign o_tap  = (i_ctl.rd && (i_index == i_ctl.idx)) ? r_data : '0;

endmodule

/* hw/rtl/plil_dec.sv */
// action decode: range checks, status, new count and cell command
module plil_dec
    import plil_pkg::*;
(
    input  logic             i_en,
    input  logic [ACT_W-1:0] i_action,
    input  logic [VAL_W-1:0] i_value,
    input  logic [POS_W-1:0] i_position,
    input  logic [CNT_W-1:0] i_count,
    output t_cell_ctl        o_ctl,
    output t_status          o_status,
    output logic [CNT_W-1:0] o_count
);

    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] pos_m1;
    logic             full;
    logic             empty;
    logic             pos_zero;
    logic             bad_ins;
    logic             bad_acc;
    logic             ins;
    logic             del;
    logic             rd;
    logic [IDX_W-1:0] idx;

    assign pos_x    = CMP_W'(i_position);
    assign cnt_x    = CMP_W'(i_count);
    assign pos_m1   = pos_x - CMP_W'(1);
    assign full     = (i_count == CNT_W'(CAPACITY));
    assign empty    = (i_count == '0);
    assign pos_zero = (i_position == '0);
    assign bad_ins  = pos_zero || (pos_x > (cnt_x + CMP_W'(1)));
    assign bad_acc  = pos_zero || (pos_x > cnt_x);

    always_comb begin
        o_status = ST_DONE;
        ins      = 1'b0;
        del      = 1'b0;
        rd       = 1'b0;
        idx      = '0;
        case (i_action)
            ACT_INS_FRONT, ACT_INS_BACK: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    ins = 1'b1;
                    idx = (i_action == ACT_INS_FRONT) ? '0 : IDX_W'(i_count);
                end
            end
            ACT_INS_AT: begin
                if (bad_ins) begin
                    o_status = ST_BAD_POS;
                end else if (full) begin
                    o_status = ST_FULL;
                end else begin
                    ins = 1'b1;
                    idx = IDX_W'(pos_m1);
                end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else begin
                    del = 1'b1;
                    idx = (i_action == ACT_DEL_FRONT) ? '0 :
                          IDX_W'(i_count - CNT_W'(1));
                end
            end
            ACT_DEL_AT: begin
                if (bad_acc) begin
                    o_status = ST_BAD_POS;
                end else begin
                    del = 1'b1;
                    idx = IDX_W'(pos_m1);
                end
            end
            ACT_READ_AT: begin
                if (bad_acc) begin
                    o_status = ST_BAD_POS;
                end else begin
                    rd  = 1'b1;
                    idx = IDX_W'(pos_m1);
                end
            end
            default: begin
                o_status = ST_DONE;
            end
        endcase
    end

    assign o_ctl.ins = ins && i_en;
    assign o_ctl.del = del && i_en;
    assign o_ctl.rd  = rd;
    assign o_ctl.idx = idx;
    assign o_ctl.val = i_value;

    assign o_count = ins ? (i_count + CNT_W'(1)) :
                     del ? (i_count - CNT_W'(1)) : i_count;

endmodule

/* hw/rtl/positional_list_insert_delete.sv */
// top level: positional list kept in a row of shifting cells
// an accepted item's result item appears on the output register in the next cycle
// throughput: one item per cycle while results are taken; cells at and above the index shift to or from a neighbor
// the output register frees in the cycle its item is taken, so both sides can move in the same cycle
// reset: synchronous active-low; clears the entry count and the output valid
// cell contents are left as they are and read only below the count
module positional_list_insert_delete
    import plil_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // action [2:0], value [34:3], position [41:35], zero fill [47:42]
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // status [1:0], length [8:2], read_value [40:9], zero fill [47:41]
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    // input item fields
    logic [ACT_W-1:0] in_action;
    logic [VAL_W-1:0] in_value;
    logic [POS_W-1:0] in_position;

    assign in_action   = i_s_axis_tdata[ACT_W-1:0];
    assign in_value    = i_s_axis_tdata[ACT_W +: VAL_W];
    assign in_position = i_s_axis_tdata[ACT_W+VAL_W +: POS_W];

    // handshake: the output register takes a new item when empty or being drained
    logic accept;
    logic r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic [OUT_W-1:0] n_out_data;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // entry count
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // decode
    t_cell_ctl cell_ctl;
    t_status   status;

    plil_dec u_dec (
        .i_en       (accept),
        .i_action   (in_action),
        .i_value    (in_value),
        .i_position (in_position),
        .i_count    (r_count),
        .o_ctl      (cell_ctl),
        .o_status   (status),
        .o_count    (n_count)
    );

    // row of cells; the ends see zero as their outer neighbor
    logic [VAL_W-1:0] cell_data [CAPACITY];
    logic [VAL_W-1:0] cell_tap  [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] left;
        logic [VAL_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_data[g+1];
        end

        plil_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctl   (cell_ctl),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[g]),
            .o_tap   (cell_tap[g])
        );
    end

    // read value: at most one tap is non-zero, so an or-combine selects it
    logic [VAL_W-1:0] rd_value;

    always_comb begin
        rd_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_value = rd_value | cell_tap[k];
        end
    end

    always_comb begin
        n_out_data = '0;
        n_out_data[STAT_W-1:0]           = status;
        n_out_data[STAT_W +: LEN_W]      = LEN_W'(n_count);
        n_out_data[STAT_W+LEN_W +: VAL_W] = rd_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // the list never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // every accepted item shows up on the output register next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_axis_tvalid)
        else $error("accepted item produced no result");

    // a full status reports a length equal to the capacity
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[STAT_W-1:0] == ST_FULL)) |->
        (o_m_axis_tdata[STAT_W +: LEN_W] == LEN_W'(CAPACITY)))
        else $error("full status with length below capacity");

    // an empty no-op reports zero length
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[STAT_W-1:0] == ST_EMPTY)) |->
        (o_m_axis_tdata[STAT_W +: LEN_W] == '0))
        else $error("empty status with nonzero length");

endmodule

/* tb/sv/tb_positional_list_insert_delete.sv */
// self-checking testbench for the positional list: directed edge cases, then random tides
module tb_positional_list_insert_delete;
    import plil_pkg::*;

    // action code the block must ignore
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
    localparam int MAX_PRINTS = 30;

    typedef struct {
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
    } t_list_cmd;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  length;
        logic [VAL_W-1:0]  read_value;
    } t_list_outcome;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    // action [2:0], value [34:3], position [41:35], zero fill [47:42]
    logic [IN_W-1:0]   i_s_axis_tdata  = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    // status [1:0], length [8:2], read_value [40:9], zero fill [47:41]
    logic [OUT_W-1:0]  o_m_axis_tdata;

    // items waiting to be offered, and results owed by the block
    t_list_cmd         cmd_backlog[$];
    t_list_outcome     due_results[$];

    // mirror of the list contents and length
    logic [VAL_W-1:0]  list_vals [CAPACITY];
    int unsigned       list_len = 0;

    // length as the generator plans it, ahead of the block
    int unsigned       plan_len = 0;

    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    logic              in_taken       = 1'b0;

    int                n_errors   = 0;
    int                n_accepted = 0;
    int                n_checked  = 0;
    int                n_status [4] = '{0, 0, 0, 0};
    int unsigned       peak_len   = 0;

    positional_list_insert_delete u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // apply one item to the mirror and return what the block should answer
    function automatic t_list_outcome apply_list_op(input logic [ACT_W-1:0] act,
                                                    input logic [VAL_W-1:0] val,
                                                    input logic [POS_W-1:0] pos);
        t_list_outcome res;
        int unsigned   at;
        res.status     = ST_DONE;
        res.read_value = '0;
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
                if (act == ACT_INS_FRONT) begin
                    at = 0;
                end else if (act == ACT_INS_BACK) begin
                    at = list_len;
                end else begin
                    at = int'(pos) - 1;
                end
                // position is judged before fullness
                if (act == ACT_INS_AT && (pos == 0 || pos > list_len + 1)) begin
                    res.status = ST_BAD_POS;
                end else if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = int'(list_len); i > int'(at); i--) begin
                        list_vals[i] = list_vals[i-1];
                    end
                    list_vals[at] = val;
                    list_len++;
                end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT: begin
                if (act == ACT_DEL_AT) begin
                    at = int'(pos) - 1;
                end else if (act == ACT_DEL_FRONT) begin
                    at = 0;
                end else begin
                    at = list_len - 1;
                end
                if (act == ACT_DEL_AT && (pos == 0 || pos > list_len)) begin
                    res.status = ST_BAD_POS;
                end else if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (int i = int'(at); i + 1 < int'(list_len); i++) begin
                        list_vals[i] = list_vals[i+1];
                    end
                    list_len--;
                end
            end
            ACT_READ_AT: begin
                if (pos == 0 || pos > list_len) begin
                    res.status = ST_BAD_POS;
                end else begin
                    res.read_value = list_vals[pos-1];
                end
            end
            default: ;
        endcase
        res.length = LEN_W'(list_len);
        return res;
    endfunction

    task automatic check_result(input logic [OUT_W-1:0] word);
        t_list_outcome want;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", word));
        end else begin
            want = due_results.pop_front();
            n_checked++;
            if (word[STAT_W-1:0] != want.status) begin
                report_mismatch($sformatf("status %0d, expected %0d",
                                          word[STAT_W-1:0], want.status));
            end
            if (word[STAT_W +: LEN_W] != want.length) begin
                report_mismatch($sformatf("length %0d, expected %0d",
                                          word[STAT_W +: LEN_W], want.length));
            end
            if (word[STAT_W+LEN_W +: VAL_W] != want.read_value) begin
                report_mismatch($sformatf("read value %h, expected %h",
                                          word[STAT_W+LEN_W +: VAL_W], want.read_value));
            end
        end
    endtask

    // monitor: results are checked before the item taken on the same edge is predicted
    always @(posedge i_clk) begin : monitor
        t_list_outcome want;
        in_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_result(o_m_axis_tdata);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                want = apply_list_op(i_s_axis_tdata[ACT_W-1:0],
                                     i_s_axis_tdata[ACT_W +: VAL_W],
                                     i_s_axis_tdata[ACT_W+VAL_W +: POS_W]);
                due_results.push_back(want);
                n_accepted++;
                n_status[want.status]++;
                if (list_len > peak_len) begin
                    peak_len = list_len;
                end
            end
        end
    end

    // driver: holds an offered item until taken, idles and stalls at random
    always @(negedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (in_taken) begin
                void'(cmd_backlog.pop_front());
            end
            if (!(i_s_axis_tvalid && !in_taken)) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {{(IN_W-ACT_W-VAL_W-POS_W){1'b0}},
                                        cmd_backlog[0].pos, cmd_backlog[0].val,
                                        cmd_backlog[0].act};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                    i_s_axis_tdata  <= IN_W'({$urandom, $urandom});
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_item(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                              input logic [POS_W-1:0] pos);
        t_list_cmd c;
        c.act = act;
        c.val = val;
        c.pos = pos;
        cmd_backlog.push_back(c);
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK: if (plan_len < CAPACITY) plan_len++;
            ACT_INS_AT: if (pos >= 1 && pos <= plan_len + 1 && plan_len < CAPACITY) plan_len++;
            ACT_DEL_FRONT, ACT_DEL_BACK: if (plan_len != 0) plan_len--;
            ACT_DEL_AT: if (pos >= 1 && pos <= plan_len) plan_len--;
            default: ;
        endcase
    endtask

    // a position outside 1..top
    function automatic logic [POS_W-1:0] bad_pos(input int unsigned top);
        if (top >= 127 || $urandom_range(2) == 0) begin
            return '0;
        end
        return POS_W'($urandom_range(127, top + 1));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // tides of growth and shrinkage so the list runs full and empty repeatedly
    task automatic run_random_phase(input int n_items);
        logic [ACT_W-1:0] act;
        logic [POS_W-1:0] pos;
        int unsigned      roll;
        bit               growing;
        bit               grow;
        growing = (plan_len < CAPACITY / 2);
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(99);
            pos  = POS_W'($urandom);
            if (roll < 4) begin
                // noise: unused code or anything at all
                act = ($urandom_range(1) == 0) ? ACT_UNUSED : ACT_W'($urandom_range(6));
            end else if (roll < 20) begin
                act = ACT_READ_AT;
                pos = (plan_len != 0 && $urandom_range(7) != 0) ?
                      POS_W'($urandom_range(plan_len, 1)) : bad_pos(plan_len);
            end else begin
                grow = growing ? ($urandom_range(99) < 75) : ($urandom_range(99) < 25);
                if (grow) begin
                    case ($urandom_range(2))
                        0: act = ACT_INS_FRONT;
                        1: act = ACT_INS_BACK;
                        default: begin
                            act = ACT_INS_AT;
                            pos = ($urandom_range(7) != 0) ?
                                  POS_W'($urandom_range(plan_len + 1, 1)) : bad_pos(plan_len + 1);
                        end
                    endcase
                end else begin
                    case ($urandom_range(2))
                        0: act = ACT_DEL_FRONT;
                        1: act = ACT_DEL_BACK;
                        default: begin
                            act = ACT_DEL_AT;
                            pos = (plan_len != 0 && $urandom_range(7) != 0) ?
                                  POS_W'($urandom_range(plan_len, 1)) : bad_pos(plan_len);
                        end
                    endcase
                end
            end
            queue_item(act, pick_value(), pos);
            // linger a few items at full or empty before turning
            if (growing && plan_len == CAPACITY && $urandom_range(3) == 0) begin
                growing = 1'b0;
            end else if (!growing && plan_len == 0 && $urandom_range(3) == 0) begin
                growing = 1'b1;
            end else if ($urandom_range(199) == 0) begin
                growing = !growing;
            end
        end
    endtask

    // hold the sender back until every owed result has come out
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || due_results.size() != 0 || i_s_axis_tvalid) begin
            @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: end deletes, positional delete and read, bad insert positions
        queue_item(ACT_DEL_FRONT, $urandom, 7'd0);
        queue_item(ACT_DEL_BACK,  $urandom, 7'd0);
        queue_item(ACT_DEL_AT,    $urandom, 7'd1);
        queue_item(ACT_READ_AT,   $urandom, 7'd1);
        queue_item(ACT_INS_AT,    $urandom, 7'd0);
        queue_item(ACT_INS_AT,    $urandom, 7'd2);
        // build five entries with extreme values
        queue_item(ACT_INS_AT,    32'h0000_0000, 7'd1);
        queue_item(ACT_INS_FRONT, 32'h8000_0000, 7'd127);
        queue_item(ACT_INS_BACK,  32'h7fff_ffff, 7'd0);
        queue_item(ACT_INS_AT,    32'hffff_ffff, 7'd4);
        queue_item(ACT_INS_AT,    32'h0000_0001, 7'd2);
        queue_item(ACT_INS_AT,    $urandom,      7'd127);
        for (int p = 1; p <= 5; p++) begin
            queue_item(ACT_READ_AT, $urandom, POS_W'(p));
        end
        queue_item(ACT_READ_AT,   $urandom, 7'd0);
        queue_item(ACT_READ_AT,   $urandom, 7'd6);
        queue_item(ACT_READ_AT,   $urandom, 7'd127);
        queue_item(ACT_UNUSED,    $urandom, 7'd3);
        // shrink it again by every delete flavor, leaving one entry
        queue_item(ACT_DEL_AT,    $urandom, 7'd0);
        queue_item(ACT_DEL_AT,    $urandom, 7'd6);
        queue_item(ACT_DEL_AT,    $urandom, 7'd3);
        queue_item(ACT_DEL_FRONT, $urandom, 7'd127);
        queue_item(ACT_DEL_BACK,  $urandom, 7'd127);
        queue_item(ACT_DEL_AT,    $urandom, 7'd1);
        wait_drained();

        // idling phases: none, sender, receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 36 : 0;
            recv_stall_pct = (ph == 2) ? 78 : (ph == 3) ? 36 : 0;
            run_random_phase(300);
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // a stray result would show up in this window
        repeat (8) @(posedge i_clk);
        if (due_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
        end
        $display("ran %0d items through four idling phases, %0d results checked, peak length %0d",
                 n_accepted, n_checked, peak_len);
        $display("outcomes: done %0d, bad position %0d, full %0d, empty %0d",
                 n_status[ST_DONE], n_status[ST_BAD_POS], n_status[ST_FULL], n_status[ST_EMPTY]);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/plil_pkg.sv
hw/rtl/plil_cell.sv
hw/rtl/plil_dec.sv
hw/rtl/positional_list_insert_delete.sv
tb/sv/tb_positional_list_insert_delete.sv
